### rtl/core/qr_function_pattern_classifier_unit_defines.svh
// Assertion macros for the QR function-pattern classifier checker.
// No dependencies; included by the checker file only.
`ifndef QR_FUNCTION_PATTERN_CLASSIFIER_UNIT_DEFINES_SVH
`define QR_FUNCTION_PATTERN_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define QRFPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define QRFPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/qrfpc_pkg.sv
// Shared types, constants and helpers for the QR function-pattern classifier.
// No dependencies; imported by all RTL files but the checker and its defines.
`timescale 1ns / 1ps

package qrfpc_pkg;

    localparam int COORD_SLOTS = 7;
    localparam int COORD_W     = 8;
    localparam int EXT_W       = COORD_W + 1;
    localparam int COUNT_W     = 3;
    localparam int CODE_W      = 2;
    localparam int NUM_COORD_REGS = 6;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 5;
    localparam int REG_IDX_W   = APB_AW - 2;

    localparam logic [COORD_W-1:0] GRID_RESET      = 8'd21;
    localparam logic [COORD_W-1:0] FIRST_COORD     = 8'd6;
    localparam logic [COORD_W-1:0] FINDER_SIZE     = 8'd7;
    localparam logic [COORD_W-1:0] FINDER_EDGE     = 8'd6;
    localparam logic [COORD_W-1:0] FINDER_CORE_LO  = 8'd2;
    localparam logic [COORD_W-1:0] FINDER_CORE_HI  = 8'd4;
    localparam logic [COORD_W-1:0] TIMING_LINE     = 8'd6;
    localparam logic [COORD_W-1:0] TIMING_FIRST    = 8'd7;
    localparam logic [COORD_W-1:0] TIMING_MIN_GRID = 8'd15;
    localparam logic [COORD_W-1:0] DARK_OFS        = 8'd8;
    localparam logic [COORD_W-1:0] DARK_COL        = 8'd8;
    localparam logic [COORD_W-1:0] ALIGN_RADIUS    = 8'd2;

    // Register index; byte address is four times the index.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_GRID_SIZE,
        REG_ALIGN_COUNT,
        REG_COORD_ONE,
        REG_COORD_TWO,
        REG_COORD_THREE,
        REG_COORD_FOUR,
        REG_COORD_FIVE,
        REG_COORD_SIX
    } t_reg_idx;

    typedef enum logic [CODE_W-1:0] {
        CODE_FREE        = 2'd0,
        CODE_FINDER      = 2'd1,
        CODE_ALIGN_LIGHT = 2'd2,
        CODE_DARK        = 2'd3
    } t_code;

    typedef logic [COORD_SLOTS-1:0] t_slot_vec;

    typedef struct packed {
        logic [COORD_W-1:0]                     grid_size;
        logic [COORD_SLOTS-1:0][COORD_W-1:0]    coord;
        logic [COORD_SLOTS-1:0][COORD_SLOTS-1:0] pair_ok;
    } t_cfg;

    // Per-slot proximity of one axis to each alignment coordinate.
    typedef struct packed {
        t_slot_vec near;   // within two modules
        t_slot_vec ring;   // exactly two modules away
        t_slot_vec ctr;    // on the coordinate
    } t_axis;

    typedef struct packed {
        logic  outside;
        t_code base;
        t_axis ax_row;
        t_axis ax_col;
    } t_s1;

    typedef struct packed {
        logic      outside;
        t_code     base;
        t_slot_vec row_hit;
        t_slot_vec row_dark;
    } t_s2;

    function automatic logic finder_dark(input logic [COORD_W-1:0] i,
                                         input logic [COORD_W-1:0] j);
        logic in_box;
        logic border;
        logic core;
        in_box = (i < FINDER_SIZE) && (j < FINDER_SIZE);
        border = (i == '0) || (i == FINDER_EDGE) || (j == '0) || (j == FINDER_EDGE);
        core   = (i >= FINDER_CORE_LO) && (i <= FINDER_CORE_HI) &&
                 (j >= FINDER_CORE_LO) && (j <= FINDER_CORE_HI);
        return in_box && (border || core);
    endfunction

endpackage

### rtl/core/qrfpc_ifs.sv
// Valid/ready channel interfaces for classifier input and result transfers.
// Depends on qrfpc_pkg.
`timescale 1ns / 1ps

interface qrfpc_in_if;
    import qrfpc_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    modport source (output valid, output row, output col, input ready);
    modport sink   (input valid, input row, input col, output ready);
endinterface

interface qrfpc_out_if;
    import qrfpc_pkg::*;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] module_code;
    logic              outside;
    modport source (output valid, output module_code, output outside, input ready);
    modport sink   (input valid, input module_code, input outside, output ready);
endinterface

### rtl/core/qrfpc_cfg_regs.sv
// APB register file: grid size, alignment count and coordinates, plus the
// registered table of alignment centers allowed for this grid. Uses qrfpc_pkg.
`timescale 1ns / 1ps

module qrfpc_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [qrfpc_pkg::APB_AW-1:0]    i_paddr,
    input  logic [qrfpc_pkg::APB_DW-1:0]    i_pwdata,
    output logic [qrfpc_pkg::APB_DW-1:0]    o_prdata,
    output logic                            o_pready,
    output qrfpc_pkg::t_cfg                 o_cfg
);
    import qrfpc_pkg::*;

    logic [COORD_W-1:0] r_grid_size;
    logic [COUNT_W-1:0] r_align_count;
    logic [COORD_W-1:0] r_coord [NUM_COORD_REGS];
    logic [COORD_SLOTS-1:0][COORD_SLOTS-1:0] r_pair_ok;
    logic [COORD_SLOTS-1:0][COORD_SLOTS-1:0] n_pair_ok;

    t_reg_idx           w_idx;
    logic [COUNT_W-1:0] w_slot;
    logic               w_wr;

    logic [COORD_SLOTS-1:0][COORD_W-1:0] w_coord;
    t_slot_vec w_en, w_in, w_lo, w_hi, w_dmx, w_dmy;
    logic [EXT_W-1:0] w_n;

    assign w_idx  = t_reg_idx'(i_paddr[APB_AW-1:2]);
    assign w_slot = COUNT_W'(w_idx - REG_COORD_ONE);
    assign w_wr   = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size   <= GRID_RESET;
            r_align_count <= '0;
            for (int k = 0; k < NUM_COORD_REGS; k++) begin
                r_coord[k] <= '0;
            end
            r_pair_ok <= '0;
        end else begin
            r_pair_ok <= n_pair_ok;
            if (w_wr) begin
                unique case (w_idx) inside
                    REG_GRID_SIZE: begin
                        r_grid_size <= i_pwdata[COORD_W-1:0];
                    end
                    REG_ALIGN_COUNT: begin
                        r_align_count <= i_pwdata[COUNT_W-1:0];
                    end
                    [REG_COORD_ONE:REG_COORD_SIX]: begin
                        r_coord[w_slot] <= i_pwdata[COORD_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_prdata = '0;
        unique case (w_idx) inside
            REG_GRID_SIZE:                o_prdata = APB_DW'(r_grid_size);
            REG_ALIGN_COUNT:              o_prdata = APB_DW'(r_align_count);
            [REG_COORD_ONE:REG_COORD_SIX]: o_prdata = APB_DW'(r_coord[w_slot]);
            default:                      o_prdata = '0;
        endcase
    end

    // A 5x5 window that touches a finder box always covers a dark finder
    // module, so blocking reduces to interval tests per axis.
    assign w_n = EXT_W'(r_grid_size);
    always_comb begin
        w_coord[0] = FIRST_COORD;
        for (int k = 1; k < COORD_SLOTS; k++) begin
            w_coord[k] = r_coord[k - 1];
        end
        for (int k = 0; k < COORD_SLOTS; k++) begin
            logic [EXT_W-1:0] c;
            c          = EXT_W'(w_coord[k]);
            w_en[k]    = (COUNT_W'(k) < r_align_count);
            w_in[k]    = (w_coord[k] >= ALIGN_RADIUS) && (c + EXT_W'(ALIGN_RADIUS) < w_n);
            w_lo[k]    = (c <= EXT_W'(ALIGN_RADIUS + FINDER_EDGE));
            w_hi[k]    = (c + EXT_W'(ALIGN_RADIUS + FINDER_SIZE) >= w_n);
            w_dmx[k]   = (r_grid_size >= DARK_OFS) &&
                         (w_n >= c + EXT_W'(DARK_OFS - ALIGN_RADIUS)) &&
                         (w_n <= c + EXT_W'(DARK_OFS + ALIGN_RADIUS));
            w_dmy[k]   = (w_coord[k] >= DARK_COL - ALIGN_RADIUS) &&
                         (w_coord[k] <= DARK_COL + ALIGN_RADIUS);
        end
        for (int i = 0; i < COORD_SLOTS; i++) begin
            for (int j = 0; j < COORD_SLOTS; j++) begin
                n_pair_ok[i][j] = w_en[i] && w_en[j] && w_in[i] && w_in[j] &&
                                  !(w_lo[i] && w_lo[j]) &&
                                  !(w_hi[i] && w_lo[j]) &&
                                  !(w_lo[i] && w_hi[j]) &&
                                  !(w_dmx[i] && w_dmy[j]);
            end
        end
    end

    assign o_cfg.grid_size = r_grid_size;
    assign o_cfg.coord     = w_coord;
    assign o_cfg.pair_ok   = r_pair_ok;

endmodule

### rtl/core/qrfpc_axis_stage.sv
// Stage 1: bounds check, base layer code (finders, timing, dark module) and
// per-axis distance to each alignment coordinate. Uses qrfpc_pkg.
`timescale 1ns / 1ps

module qrfpc_axis_stage (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [qrfpc_pkg::COORD_W-1:0]   i_row,
    input  logic [qrfpc_pkg::COORD_W-1:0]   i_col,
    input  qrfpc_pkg::t_cfg                 i_cfg,
    output logic                            o_valid,
    input  logic                            i_ready,
    output qrfpc_pkg::t_s1                  o_data
);
    import qrfpc_pkg::*;

    logic r_valid;
    t_s1  r_data;
    t_s1  n_data;

    logic [COORD_W-1:0] w_n;
    logic               w_dark_mod;
    logic               w_timing;
    logic               w_finder;

    assign w_n = i_cfg.grid_size;

    always_comb begin
        w_dark_mod = (w_n >= DARK_OFS) && (i_row == w_n - DARK_OFS) && (i_col == DARK_COL);
        w_timing   = (w_n >= TIMING_MIN_GRID) &&
                     (((i_row == TIMING_LINE) && (i_col >= TIMING_FIRST) &&
                       (i_col <= w_n - DARK_OFS) && !i_col[0]) ||
                      ((i_col == TIMING_LINE) && (i_row >= TIMING_FIRST) &&
                       (i_row <= w_n - DARK_OFS) && !i_row[0]));
        w_finder   = finder_dark(i_row, i_col) ||
                     finder_dark(w_n - 8'd1 - i_row, i_col) ||
                     finder_dark(i_row, w_n - 8'd1 - i_col);

        n_data.outside = (i_row >= w_n) || (i_col >= w_n);
        if (w_dark_mod)    n_data.base = CODE_FINDER;
        else if (w_timing) n_data.base = CODE_DARK;
        else if (w_finder) n_data.base = CODE_FINDER;
        else               n_data.base = CODE_FREE;

        for (int k = 0; k < COORD_SLOTS; k++) begin
            logic [EXT_W-1:0] a, r, c;
            a = EXT_W'(i_cfg.coord[k]);
            r = EXT_W'(i_row);
            c = EXT_W'(i_col);
            n_data.ax_row.near[k] = (r + EXT_W'(ALIGN_RADIUS) >= a) &&
                                    (r <= a + EXT_W'(ALIGN_RADIUS));
            n_data.ax_row.ring[k] = (r == a + EXT_W'(ALIGN_RADIUS)) ||
                                    (r + EXT_W'(ALIGN_RADIUS) == a);
            n_data.ax_row.ctr[k]  = (r == a);
            n_data.ax_col.near[k] = (c + EXT_W'(ALIGN_RADIUS) >= a) &&
                                    (c <= a + EXT_W'(ALIGN_RADIUS));
            n_data.ax_col.ring[k] = (c == a + EXT_W'(ALIGN_RADIUS)) ||
                                    (c + EXT_W'(ALIGN_RADIUS) == a);
            n_data.ax_col.ctr[k]  = (c == a);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/core/qrfpc_pair_stage.sv
// Stage 2: for each row-coordinate slot, find the last column slot whose
// alignment pattern covers the module, and whether it is dark. Uses qrfpc_pkg.
`timescale 1ns / 1ps

module qrfpc_pair_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  qrfpc_pkg::t_s1  i_data,
    input  qrfpc_pkg::t_cfg i_cfg,
    output logic            o_valid,
    input  logic            i_ready,
    output qrfpc_pkg::t_s2  o_data
);
    import qrfpc_pkg::*;

    logic r_valid;
    t_s2  r_data;
    t_s2  n_data;

    always_comb begin
        n_data.outside  = i_data.outside;
        n_data.base     = i_data.base;
        n_data.row_hit  = '0;
        n_data.row_dark = '0;
        for (int i = 0; i < COORD_SLOTS; i++) begin
            // later column slots overwrite earlier ones
            for (int j = 0; j < COORD_SLOTS; j++) begin
                if (i_data.ax_row.near[i] && i_data.ax_col.near[j] &&
                    i_cfg.pair_ok[i][j]) begin
                    n_data.row_hit[i]  = 1'b1;
                    n_data.row_dark[i] = i_data.ax_row.ring[i] || i_data.ax_col.ring[j] ||
                                         (i_data.ax_row.ctr[i] && i_data.ax_col.ctr[j]);
                end
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/core/qrfpc_pick_stage.sv
// Stage 3: last covering alignment row wins over the base code; outside forces
// code free; result register that drives the output channel. Uses qrfpc_pkg.
`timescale 1ns / 1ps

module qrfpc_pick_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  qrfpc_pkg::t_s2                i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [qrfpc_pkg::CODE_W-1:0]  o_module_code,
    output logic                          o_outside
);
    import qrfpc_pkg::*;

    logic  r_valid;
    t_code r_code;
    logic  r_outside;
    t_code n_code;

    always_comb begin
        n_code = i_data.base;
        for (int i = 0; i < COORD_SLOTS; i++) begin
            if (i_data.row_hit[i]) begin
                n_code = i_data.row_dark[i] ? CODE_DARK : CODE_ALIGN_LIGHT;
            end
        end
        if (i_data.outside) begin
            n_code = CODE_FREE;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_code    <= n_code;
            r_outside <= i_data.outside;
        end
    end

    assign o_valid       = r_valid;
    assign o_module_code = CODE_W'(r_code);
    assign o_outside     = r_outside;

endmodule

### rtl/core/qr_function_pattern_classifier_unit.sv
// QR function-pattern classifier: one module coordinate in, one map code out.
// A result passes through the axis, pair and pick stage registers in that order.
// Throughput: one coordinate per cycle; each stage stalls only when the one after
// it is full and held, so bubbles close up under output backpressure.
// Reset (synchronous, active low) empties all stages and loads register defaults;
// the allowed-center table follows any register write in the following cycle.
`timescale 1ns / 1ps

module qr_function_pattern_classifier_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    qrfpc_in_if.sink                        i_in,
    qrfpc_out_if.source                     o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [qrfpc_pkg::APB_AW-1:0]    paddr,
    input  logic [qrfpc_pkg::APB_DW-1:0]    pwdata,
    output logic [qrfpc_pkg::APB_DW-1:0]    prdata,
    output logic                            pready
);
    import qrfpc_pkg::*;

    t_cfg w_cfg;
    t_s1  w_s1;
    t_s2  w_s2;
    logic w_s1_valid, w_s1_ready;
    logic w_s2_valid, w_s2_ready;

    qrfpc_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    qrfpc_axis_stage u_axis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_row   (i_in.row),
        .i_col   (i_in.col),
        .i_cfg   (w_cfg),
        .o_valid (w_s1_valid),
        .i_ready (w_s1_ready),
        .o_data  (w_s1)
    );

    qrfpc_pair_stage u_pair (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .o_ready (w_s1_ready),
        .i_data  (w_s1),
        .i_cfg   (w_cfg),
        .o_valid (w_s2_valid),
        .i_ready (w_s2_ready),
        .o_data  (w_s2)
    );

    qrfpc_pick_stage u_pick (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_s2_valid),
        .o_ready       (w_s2_ready),
        .i_data        (w_s2),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_module_code (o_out.module_code),
        .o_outside     (o_out.outside)
    );

endmodule

### rtl/core/qrfpc_checker.sv
// Port-level checks for the classifier and the bind that attaches them.
// Depends on qr_function_pattern_classifier_unit_defines.svh.
`timescale 1ns / 1ps
`include "qr_function_pattern_classifier_unit_defines.svh"

module qrfpc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_code,
    input logic       i_out_outside
);

    // a result appearing on an empty output came through all three stages
    `QRFPC_ASSERT_IMP(a_result_latency, i_clk, i_rst_n, $rose(i_out_valid), $past(i_in_valid && i_in_ready, 3), "result without input transfer three cycles earlier")

    // input backpressure only when the whole pipe is blocked at the output
    `QRFPC_ASSERT_IMP(a_ready_backpressure, i_clk, i_rst_n, !i_in_ready, i_out_valid && !i_out_ready, "input stalled while output not blocked")

    `QRFPC_ASSERT_NXT(a_result_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_code) && $stable(i_out_outside), "stalled result changed")

endmodule

bind qr_function_pattern_classifier_unit qrfpc_checker u_qrfpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_code    (o_out.module_code),
    .i_out_outside (o_out.outside)
);
